// ===== hdl/psrc_pkg.sv =====
// Package for the polyphase sample rate converter stage: constants and helpers.
package psrc_pkg;

   localparam int COEF_DEPTH_DEF      = 1024;
   localparam int FIR_DELAY_DEPTH_DEF = 1024;
   localparam int OUT_DELAY_DEPTH_DEF = 256;
   localparam int MAX_SUBFILTERS_DEF  = 64;

   localparam int BASE_SHIFT   = 23;
   localparam int MAX_BLOCK_IN = 512;

   // Configuration register indexes.
   localparam logic [2:0] REG_BLOCK_IN  = 3'd0;
   localparam logic [2:0] REG_NUM_SUB   = 3'd1;
   localparam logic [2:0] REG_TAPS      = 3'd2;
   localparam logic [2:0] REG_IN_STEP   = 3'd3;
   localparam logic [2:0] REG_OUT_STEP  = 3'd4;
   localparam logic [2:0] REG_SHIFT     = 3'd5;
   localparam logic [2:0] REG_IN24      = 3'd6;

   // Input item kinds.
   localparam logic ACT_SAMPLE = 1'b0;
   localparam logic ACT_COEF   = 1'b1;

   // Arithmetic right shift of the accumulator and saturation to 32 bits.
   function automatic logic [31:0] scale_sat(input logic [63:0] acc, input logic [5:0] sh);
      logic signed [63:0] q;
      begin
         q = $signed(acc) >>> sh;
         if (q > 64'sh7FFFFFFF)
            scale_sat = 32'h7FFFFFFF;
         else if (q < -64'sh80000000)
            scale_sat = 32'h80000000;
         else
            scale_sat = q[31:0];
      end
   endfunction

endpackage

// ===== hdl/psrc_mac.sv =====
// Shared multiply-accumulate unit: registered product, then 64-bit accumulate.
module psrc_mac (
   input  logic        clock,
   input  logic        clear,
   input  logic        en,
   input  logic [31:0] a,
   input  logic [31:0] b,
   output logic [63:0] acc
);
   logic [63:0] prod_ff;
   logic        pv_ff;
   logic [63:0] acc_ff;
   logic [63:0] acc_in;

   // Product stage; the 64-bit target widens the signed 32 by 32 product.
   always_ff @(posedge clock) begin
      prod_ff <= $signed(a) * $signed(b);
      pv_ff   <= en;
   end

   // Accumulate stage, wraps modulo two to the 64.
   always_comb begin
      acc_in = acc_ff;
      if (clear)
         acc_in = '0;
      else if (pv_ff)
         acc_in = acc_ff + prod_ff;
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   assign acc = acc_ff;
endmodule

// ===== hdl/polyphase_src_fir_stage_unit.sv =====
// Top level of the polyphase FIR sample rate converter stage with its sequencer.
// A coefficient write or non-final sample is stored directly; the final sample
// of a block runs the MAC loop over every subfilter and its taps, storing each result,
// then results are read out of the output delay line and emitted as they are taken.
// One item is in work at a time; the single shared multiplier sets the rate.
// Reset is synchronous: after it the block sweeps both delay lines clear,
// and accepts no item until the sweep ends.
module polyphase_src_fir_stage_unit #(
   parameter int COEF_DEPTH      = psrc_pkg::COEF_DEPTH_DEF,
   parameter int FIR_DELAY_DEPTH = psrc_pkg::FIR_DELAY_DEPTH_DEF,
   parameter int OUT_DELAY_DEPTH = psrc_pkg::OUT_DELAY_DEPTH_DEF,
   parameter int MAX_SUBFILTERS  = psrc_pkg::MAX_SUBFILTERS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic        req_tuser,   // action
   input  logic [79:0] req_tdata,   // sample_in[31:0], coef_index[41:32], coef_value[73:42]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // sample_out[31:0]
   output logic        rsp_tlast,   // last
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [10:0] csr_wdata
);
   import psrc_pkg::*;

   localparam int CW = $clog2(COEF_DEPTH);
   localparam int FW = $clog2(FIR_DELAY_DEPTH);
   localparam int OW = $clog2(OUT_DELAY_DEPTH);
   localparam int CLW = (FW > OW) ? FW : OW;

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_MAC   = 3'd2;
   localparam logic [2:0] ST_DRAIN = 3'd3;
   localparam logic [2:0] ST_STORE = 3'd4;
   localparam logic [2:0] ST_EMIT  = 3'd5;
   localparam logic [2:0] ST_READ  = 3'd6;

   // Configuration registers.
   logic [9:0]  blk_ff;
   logic [6:0]  nsub_ff;
   logic [10:0] taps_ff, istep_ff;
   logic [7:0]  ostep_ff;
   logic [4:0]  shift_ff;
   logic        in24_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         blk_ff <= 10'd1; nsub_ff <= 7'd1; taps_ff <= 11'd1; istep_ff <= 11'd1;
         ostep_ff <= 8'd1; shift_ff <= 5'd0; in24_ff <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            REG_BLOCK_IN: blk_ff   <= csr_wdata[9:0];
            REG_NUM_SUB:  nsub_ff  <= csr_wdata[6:0];
            REG_TAPS:     taps_ff  <= csr_wdata;
            REG_IN_STEP:  istep_ff <= csr_wdata;
            REG_OUT_STEP: ostep_ff <= csr_wdata[7:0];
            REG_SHIFT:    shift_ff <= csr_wdata[4:0];
            REG_IN24:     in24_ff  <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // Derived sizes; configuration must stay static while items flow (not enforced here).
   logic [24:0] prod_ct, prod_fi, fsize_w;
   logic [24:0] osize_w;
   logic        cfg_ok;
   always_comb begin
      prod_ct = 25'(nsub_ff) * 25'(taps_ff);
      prod_fi = 25'(nsub_ff - 7'd1) * 25'(istep_ff);
      fsize_w = 25'(taps_ff) + prod_fi + 25'(blk_ff);
      osize_w = 25'd1 + 25'(nsub_ff - 7'd1) * 25'(ostep_ff);
      cfg_ok = (blk_ff != 0) && (blk_ff <= 10'(MAX_BLOCK_IN)) && (nsub_ff != 0) &&
               (32'(nsub_ff) <= 32'(MAX_SUBFILTERS)) && (taps_ff != 0) &&
               (istep_ff != 0) && (ostep_ff != 0) && (32'(prod_ct) <= 32'(COEF_DEPTH)) &&
               (32'(fsize_w) <= 32'(FIR_DELAY_DEPTH)) && (32'(osize_w) <= 32'(OUT_DELAY_DEPTH));
   end
   logic [FW:0] fsize;
   logic [OW:0] osize;
   assign fsize = (FW+1)'(fsize_w);
   assign osize = (OW+1)'(osize_w);

   // Memories.
   logic [31:0] coef_mem [COEF_DEPTH];
   logic [31:0] fir_mem  [FIR_DELAY_DEPTH];
   logic [31:0] out_mem  [OUT_DELAY_DEPTH];

   logic [2:0]  state_ff, state_in;
   logic [CLW:0] clr_ff, clr_in;
   logic [FW:0] wpos_ff, wpos_in;
   logic [OW:0] rpos_ff, rpos_in;
   logic [9:0]  sib_ff, sib_in;
   logic [FW:0] r_ff, r_in, ri_ff, ri_in;
   logic [CW:0] ci_ff, ci_in;
   logic [10:0] t_ff, t_in;
   logic [6:0]  f_ff, f_in, n_ff, n_in;
   logic [OW:0] ow_ff, ow_in;
   logic [1:0]  dr_ff, dr_in;
   logic        rv_ff, rv_in, rl_ff, rl_in;
   logic [31:0] rd_ff;

   logic [31:0] cdat_ff, fdat_ff, odat_ff;
   logic        rd_en, mac_en_ff;
   logic        mac_clear;
   logic [63:0] acc;

   logic        accept;
   logic        is_coef;
   logic [31:0] smp;
   logic [FW:0] wp0, wp1;
   logic [FW+12:0] rstart;

   assign accept  = req_tvalid && req_tready;
   assign is_coef = (req_tuser == ACT_COEF);
   assign smp = in24_ff ? {{8{req_tdata[23]}}, req_tdata[23:0]} : req_tdata[31:0];
   assign wp0 = (wpos_ff >= fsize) ? '0 : wpos_ff;
   assign wp1 = (wp0 + 1'b1 >= fsize) ? '0 : wp0 + 1'b1;
   // Start read point: wp1 + fsize - blk - (nsub-1)*istep, which lies in [0, 2*fsize).
   assign rstart = (FW+13)'(wp1) + (FW+13)'(fsize) - (FW+13)'(blk_ff) - (FW+13)'(prod_fi);

   assign req_tready = (state_ff == ST_IDLE);

   // Shared multiply-accumulate.
   psrc_mac u_mac (
      .clock (clock), .clear (mac_clear), .en (mac_en_ff),
      .a (cdat_ff), .b (fdat_ff), .acc (acc)
   );

   // Sequencer.
   always_comb begin
      state_in = state_ff; clr_in = clr_ff; wpos_in = wpos_ff; rpos_in = rpos_ff;
      sib_in = sib_ff; r_in = r_ff; ri_in = ri_ff; ci_in = ci_ff; t_in = t_ff;
      f_in = f_ff; n_in = n_ff; ow_in = ow_ff; dr_in = dr_ff;
      rv_in = rv_ff; rl_in = rl_ff; rd_en = 1'b0; mac_clear = 1'b0;
      if (rv_ff && rsp_tready) rv_in = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + 1'b1;
            if (32'(clr_ff) >= FIR_DELAY_DEPTH - 1 && 32'(clr_ff) >= OUT_DELAY_DEPTH - 1)
               state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (accept && !is_coef && cfg_ok) begin
               wpos_in = wp1;
               if (sib_ff + 10'd1 >= blk_ff) begin
                  sib_in = '0;
                  r_in = (rstart >= (FW+13)'(fsize)) ? (FW+1)'(rstart - (FW+13)'(fsize))
                                                     : (FW+1)'(rstart);
                  ri_in = r_in;
                  ow_in = (rpos_ff >= osize) ? '0 : rpos_ff;
                  rpos_in = ow_in;
                  ci_in = '0; t_in = '0; f_in = '0;
                  mac_clear = 1'b1;
                  state_in = ST_MAC;
               end else begin
                  sib_in = sib_ff + 10'd1;
               end
            end
         end
         ST_MAC: begin
            rd_en = 1'b1;
            ci_in = ci_ff + 1'b1;
            ri_in = (ri_ff == 0) ? fsize - 1'b1 : ri_ff - 1'b1;
            t_in = t_ff + 11'd1;
            if (t_ff + 11'd1 >= taps_ff) begin
               dr_in = 2'd3;
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            // Wait for read, product and accumulate registers.
            dr_in = dr_ff - 2'd1;
            if (dr_ff == 2'd1) state_in = ST_STORE;
         end
         ST_STORE: begin
            mac_clear = 1'b1;
            ow_in = ((ow_ff + (OW+1)'(ostep_ff)) >= osize) ?
                    ow_ff + (OW+1)'(ostep_ff) - osize : ow_ff + (OW+1)'(ostep_ff);
            r_in = (r_ff + (FW+1)'(istep_ff) >= fsize) ?
                   r_ff + (FW+1)'(istep_ff) - fsize : r_ff + (FW+1)'(istep_ff);
            ri_in = r_in; t_in = '0;
            f_in = f_ff + 7'd1;
            if (f_ff + 7'd1 >= nsub_ff) begin
               n_in = '0;
               state_in = ST_READ;
            end else begin
               state_in = ST_MAC;
            end
         end
         ST_READ: begin
            // Output memory read is registered; wait for the slot to free.
            if (!rv_ff || rsp_tready) state_in = ST_EMIT;
         end
         ST_EMIT: begin
            rv_in = 1'b1;
            rl_in = (n_ff + 7'd1 == nsub_ff);
            rpos_in = (rpos_ff + 1'b1 >= osize) ? '0 : rpos_ff + 1'b1;
            n_in = n_ff + 7'd1;
            state_in = (n_ff + 7'd1 == nsub_ff) ? ST_IDLE : ST_READ;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR; clr_ff <= '0; wpos_ff <= '0; rpos_ff <= '0; sib_ff <= '0;
         rv_ff <= 1'b0; mac_en_ff <= 1'b0;
      end else begin
         state_ff <= state_in; clr_ff <= clr_in; wpos_ff <= wpos_in; rpos_ff <= rpos_in;
         sib_ff <= sib_in; rv_ff <= rv_in; mac_en_ff <= rd_en;
      end
      r_ff <= r_in; ri_ff <= ri_in; ci_ff <= ci_in; t_ff <= t_in; f_ff <= f_in;
      n_ff <= n_in; ow_ff <= ow_in; dr_ff <= dr_in; rl_ff <= rl_in;
      if (state_ff == ST_EMIT) rd_ff <= odat_ff;
   end

   // Coefficient memory.
   always_ff @(posedge clock) begin
      if (accept && is_coef && 32'(req_tdata[41:32]) < COEF_DEPTH)
         coef_mem[CW'(req_tdata[41:32])] <= req_tdata[73:42];
      cdat_ff <= coef_mem[ci_ff[CW-1:0]];
   end

   // FIR delay line: cleared by the sweep, written per sample.
   always_ff @(posedge clock) begin
      if (state_ff == ST_CLEAR) begin
         if (32'(clr_ff) < FIR_DELAY_DEPTH) fir_mem[clr_ff[FW-1:0]] <= '0;
      end else if (accept && !is_coef && cfg_ok) begin
         fir_mem[wp0[FW-1:0]] <= smp;
      end
      fdat_ff <= fir_mem[ri_ff[FW-1:0]];
   end

   // Output delay line.
   always_ff @(posedge clock) begin
      if (state_ff == ST_CLEAR) begin
         if (32'(clr_ff) < OUT_DELAY_DEPTH) out_mem[clr_ff[OW-1:0]] <= '0;
      end else if (state_ff == ST_STORE) begin
         out_mem[ow_ff[OW-1:0]] <= scale_sat(acc, 6'(BASE_SHIFT) + 6'(shift_ff));
      end
      odat_ff <= out_mem[rpos_ff[OW-1:0]];
   end

   assign rsp_tvalid = rv_ff;
   assign rsp_tdata  = rd_ff;
   assign rsp_tlast  = rl_ff;

   // Checks.
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_IDLE |-> !accept) else $error("item accepted while busy");
   a_emit_slot_free: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EMIT |-> (!rv_ff || rsp_tready)) else $error("result overwritten");
   a_mac_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_MAC |-> ri_ff < fsize) else $error("delay read out of line");
endmodule
